FILE: hw/rtl/aie_pkg.sv
// ----------------------------------------------------------------------------
// aie_pkg
// Shared types and constants for the ARP / ICMP echo responder.
// ----------------------------------------------------------------------------
package aie_pkg;

    localparam int MAX_FRAME_DEF = 2048;
    localparam int HDR_BYTES     = 46;   // enough for a tagged ARP header
    localparam int L3_BYTES      = 28;
    localparam int SUM_W         = 30;

    localparam logic [15:0] ETH_VLAN = 16'h8100;
    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    localparam logic [1:0] KIND_VERDICT = 2'd1;
    localparam logic [1:0] KIND_BYTE    = 2'd2;

    localparam logic [0:0] REG_OWN_MAC = 1'b0;
    localparam logic [0:0] REG_OWN_IP  = 1'b1;

    typedef enum logic [2:0] {
        VERDICT_ARP       = 3'd0,
        VERDICT_LEARN     = 3'd1,
        VERDICT_ECHO      = 3'd2,
        VERDICT_IGNORE    = 3'd3,
        VERDICT_MALFORMED = 3'd4
    } verdict_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PULL,
        ST_CLASS,
        ST_IC_A,
        ST_IC_B,
        ST_IC_C,
        ST_STREAM,
        ST_DRAIN,
        ST_FOLD1,
        ST_FOLD2,
        ST_WR0,
        ST_WR1,
        ST_WR2,
        ST_WR3,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  verdict;
        logic [7:0]  data;
        logic        last;
        logic [47:0] learned;
    } res_t;

    function automatic logic [7:0] mac_byte(input logic [47:0] v, input logic [2:0] i);
        logic [7:0] b;
        case (i)
            3'd0:    b = v[47:40];
            3'd1:    b = v[39:32];
            3'd2:    b = v[31:24];
            3'd3:    b = v[23:16];
            3'd4:    b = v[15:8];
            default: b = v[7:0];
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ip_byte(input logic [31:0] v, input logic [1:0] i);
        logic [7:0] b;
        case (i)
            2'd0:    b = v[31:24];
            2'd1:    b = v[23:16];
            2'd2:    b = v[15:8];
            default: b = v[7:0];
        endcase
        return b;
    endfunction

endpackage

FILE: hw/rtl/aie_req_if.sv
// ----------------------------------------------------------------------------
// aie_req_if
// Command channel: push a received frame byte or pull a reply byte.
// ----------------------------------------------------------------------------
interface aie_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, command, data_byte, last_byte, input ready);
    modport sink   (input valid, command, data_byte, last_byte, output ready);
endinterface

FILE: hw/rtl/aie_rsp_if.sv
// ----------------------------------------------------------------------------
// aie_rsp_if
// Result channel: frame verdicts and reply bytes.
// ----------------------------------------------------------------------------
interface aie_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  verdict;
    logic [7:0]  reply_data;
    logic        reply_last;
    logic [47:0] learned_mac;

    modport source (output valid, kind, verdict, reply_data, reply_last, learned_mac,
                    input ready);
    modport sink   (input valid, kind, verdict, reply_data, reply_last, learned_mac,
                    output ready);
endinterface

FILE: hw/rtl/aie_ram.sv
// ----------------------------------------------------------------------------
// aie_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module aie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: hw/rtl/aie_engine.sv
// ----------------------------------------------------------------------------
// aie_engine
// Frame store, classifier, reply builder with checksum walk, reply readout.
// ----------------------------------------------------------------------------
module aie_engine #(
    parameter int MAX_FRAME = aie_pkg::MAX_FRAME_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [47:0]    own_mac,
    input  logic [31:0]    own_ip,
    aie_req_if.sink        req,
    output logic           res_valid,
    output aie_pkg::res_t  res,
    input  logic           res_ready
);
    import aie_pkg::*;

    localparam int AW = $clog2(MAX_FRAME);
    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam int HW = $clog2(HDR_BYTES);

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic               pend_reg, pend_next;
    logic [CW-1:0]      rlen_reg, rlen_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic               lastb_reg, lastb_next;
    logic [47:0]        learned_reg, learned_next;
    verdict_t           verdict_reg, verdict_next;
    logic               arp_reg, arp_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [CW-1:0]      blen_reg, blen_next;
    logic               s2v_reg, s2v_next;

    logic [7:0]         hdr_reg [HDR_BYTES];
    logic [5:0]         ihl_reg, ihl_next;
    logic [15:0]        tot_reg, tot_next;
    logic [7:0]         type_reg, type_next;
    logic [CW-1:0]      k2_reg;
    logic [SUM_W-1:0]   ipsum_reg, icsum_reg;

    logic               fr_we, fr_re, rp_we, rp_re, hdr_we;
    logic [AW-1:0]      fr_raddr, rp_waddr;
    logic [7:0]         fr_rdata, rp_rdata, rp_wdata;

    logic [7:0]         l3 [L3_BYTES];
    logic               vlan;
    logic [CW-1:0]      l2, n;
    logic [15:0]        tot_c;
    logic [5:0]         ihl_c;
    logic [31:0]        sa, da, nsrc;

    logic [CW-1:0]      j;
    logic [7:0]         s2_byte;
    logic [15:0]        s2_word;
    logic               add_ip, add_ic;
    logic [15:0]        ipc, icc;

    aie_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_frame_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (req.data_byte),
        .re    (fr_re),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    aie_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_reply_ram (
        .clk   (clk),
        .we    (rp_we),
        .waddr (rp_waddr),
        .wdata (rp_wdata),
        .re    (rp_re),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (rp_rdata)
    );

    // header view past the optional tag
    always_comb
    begin
        vlan = {hdr_reg[12], hdr_reg[13]} == ETH_VLAN;
        for (int i = 0; i < L3_BYTES; i++)
        begin
            l3[i] = vlan ? hdr_reg[i + 18] : hdr_reg[i + 14];
        end
        l2    = vlan ? CW'(18) : CW'(14);
        n     = count_reg;
        tot_c = {l3[2], l3[3]};
        ihl_c = {l3[0][3:0], 2'b00};
        sa    = {l3[12], l3[13], l3[14], l3[15]};
        da    = {l3[16], l3[17], l3[18], l3[19]};
        if (da[31:24] == 8'hE0)
        begin
            nsrc = (sa & 32'hFFFFFFFC) | ((sa[1:0] == 2'd1) ? 32'h00000002 : 32'h00000003 & 32'h1);
        end
        else
        begin
            nsrc = da;
        end
    end

    // builder write stage
    always_comb
    begin
        j       = k2_reg - CW'(14);
        s2_byte = fr_rdata;
        add_ip  = 1'b0;
        add_ic  = 1'b0;
        if (k2_reg < CW'(6))
        begin
            s2_byte = fr_rdata;
        end
        else if (k2_reg < CW'(12))
        begin
            s2_byte = mac_byte(own_mac, 3'(k2_reg - CW'(6)));
        end
        else if (arp_reg)
        begin
            if (k2_reg < CW'(22))
            begin
                case (k2_reg[4:0])
                    5'd12:   s2_byte = 8'h08;
                    5'd13:   s2_byte = 8'h06;
                    5'd15:   s2_byte = 8'h01;
                    5'd16:   s2_byte = 8'h08;
                    5'd18:   s2_byte = 8'h06;
                    5'd19:   s2_byte = 8'h04;
                    5'd21:   s2_byte = 8'h02;
                    default: s2_byte = 8'h00;
                endcase
            end
            else if (k2_reg < CW'(28))
            begin
                s2_byte = mac_byte(own_mac, 3'(k2_reg - CW'(22)));
            end
            else if (k2_reg < CW'(32))
            begin
                s2_byte = ip_byte(own_ip, 2'(k2_reg - CW'(28)));
            end
        end
        else if (k2_reg == CW'(12))
        begin
            s2_byte = 8'h08;
        end
        else if (k2_reg == CW'(13))
        begin
            s2_byte = 8'h00;
        end
        else
        begin
            if (j >= CW'(12) && j < CW'(16))
            begin
                s2_byte = ip_byte(nsrc, 2'(j - CW'(12)));
            end
            else if (j >= CW'(16) && j < CW'(20))
            begin
                s2_byte = ip_byte(sa, 2'(j - CW'(16)));
            end
            else if (j == CW'(ihl_reg))
            begin
                s2_byte = 8'h00;
            end
            if (j < CW'(ihl_reg))
            begin
                add_ip = (j != CW'(10)) && (j != CW'(11));
            end
            else
            begin
                add_ic = (j != CW'(ihl_reg) + CW'(2)) && (j != CW'(ihl_reg) + CW'(3));
            end
        end
        s2_word = j[0] ? {8'h00, s2_byte} : {s2_byte, 8'h00};
        ipc     = ~ipsum_reg[15:0];
        if (ipc == 16'h0000)
        begin
            ipc = 16'hFFFF;
        end
        icc = ~icsum_reg[15:0];
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        pend_next    = pend_reg;
        rlen_next    = rlen_reg;
        ptr_next     = ptr_reg;
        lastb_next   = lastb_reg;
        learned_next = learned_reg;
        verdict_next = verdict_reg;
        arp_next     = arp_reg;
        k_next       = k_reg;
        blen_next    = blen_reg;
        s2v_next     = 1'b0;
        ihl_next     = ihl_reg;
        tot_next     = tot_reg;
        type_next    = type_reg;
        req.ready    = 1'b0;
        fr_we        = 1'b0;
        fr_re        = 1'b0;
        fr_raddr     = '0;
        rp_re        = 1'b0;
        rp_we        = s2v_reg;
        rp_waddr     = k2_reg[AW-1:0];
        rp_wdata     = s2_byte;
        hdr_we       = 1'b0;
        res_valid    = 1'b0;
        res.kind     = KIND_VERDICT;
        res.verdict  = verdict_reg;
        res.data     = 8'h00;
        res.last     = 1'b0;
        res.learned  = learned_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    if (req.command == CMD_PUSH)
                    begin
                        hdr_we = count_reg < CW'(HDR_BYTES);
                        if (count_reg < CW'(MAX_FRAME))
                        begin
                            fr_we      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (req.last_byte)
                        begin
                            state_next = ST_CLASS;
                        end
                    end
                    else if (pend_reg && ptr_reg < rlen_reg)
                    begin
                        rp_re      = 1'b1;
                        ptr_next   = ptr_reg + CW'(1);
                        lastb_next = ptr_reg + CW'(1) >= rlen_reg;
                        if (ptr_reg + CW'(1) >= rlen_reg)
                        begin
                            pend_next = 1'b0;
                        end
                        state_next = ST_PULL;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end
            end

            ST_PULL:
            begin
                res_valid   = 1'b1;
                res.kind    = KIND_BYTE;
                res.verdict = 3'd0;
                res.data    = rp_rdata;
                res.last    = lastb_reg;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_CLASS:
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                state_next = ST_EMIT;
                k_next     = '0;
                if (ovf_reg || n < CW'(14) || (vlan && n < CW'(18)))
                begin
                    verdict_next = VERDICT_MALFORMED;
                end
                else if ((vlan ? {hdr_reg[16], hdr_reg[17]} : {hdr_reg[12], hdr_reg[13]})
                         == ETH_ARP)
                begin
                    if (n < l2 + CW'(28))
                    begin
                        verdict_next = VERDICT_MALFORMED;
                    end
                    else if ({l3[0], l3[1]} != 16'h0001 || {l3[2], l3[3]} != ETH_IPV4 ||
                             l3[4] != 8'd6 || l3[5] != 8'd4 ||
                             {l3[24], l3[25], l3[26], l3[27]} != own_ip)
                    begin
                        verdict_next = VERDICT_IGNORE;
                    end
                    else if ({l3[6], l3[7]} == 16'h0001)
                    begin
                        verdict_next = VERDICT_ARP;
                        arp_next     = 1'b1;
                        blen_next    = CW'(42);
                        state_next   = ST_STREAM;
                    end
                    else if ({l3[6], l3[7]} == 16'h0002)
                    begin
                        verdict_next = VERDICT_LEARN;
                        learned_next = {l3[8], l3[9], l3[10], l3[11], l3[12], l3[13]};
                    end
                    else
                    begin
                        verdict_next = VERDICT_IGNORE;
                    end
                end
                else if ((vlan ? {hdr_reg[16], hdr_reg[17]} : {hdr_reg[12], hdr_reg[13]})
                         != ETH_IPV4)
                begin
                    verdict_next = VERDICT_IGNORE;
                end
                else if (n < l2 + CW'(20) || ihl_c < 6'd20)
                begin
                    verdict_next = VERDICT_MALFORMED;
                end
                else if (l3[9] != 8'd1)
                begin
                    verdict_next = VERDICT_IGNORE;
                end
                else if ({1'b0, tot_c} > 17'(n - l2) || {1'b0, tot_c} < 17'(ihl_c) + 17'd8)
                begin
                    verdict_next = VERDICT_MALFORMED;
                end
                else
                begin
                    ihl_next   = ihl_c;
                    tot_next   = tot_c;
                    state_next = ST_IC_A;
                end
            end

            ST_IC_A:
            begin
                fr_re      = 1'b1;
                fr_raddr   = AW'(l2 + CW'(ihl_reg));
                state_next = ST_IC_B;
            end

            ST_IC_B:
            begin
                fr_re      = 1'b1;
                fr_raddr   = AW'(l2 + CW'(ihl_reg) + CW'(1));
                type_next  = fr_rdata;
                state_next = ST_IC_C;
            end

            ST_IC_C:
            begin
                if (type_reg == 8'd8 && fr_rdata == 8'd0)
                begin
                    verdict_next = VERDICT_ECHO;
                    arp_next     = 1'b0;
                    blen_next    = CW'(14) + CW'(tot_reg);
                    state_next   = ST_STREAM;
                end
                else
                begin
                    verdict_next = VERDICT_IGNORE;
                    state_next   = ST_EMIT;
                end
            end

            ST_STREAM:
            begin
                fr_re = 1'b1;
                if (k_reg < CW'(6))
                begin
                    fr_raddr = AW'(k_reg + CW'(6));
                end
                else if (arp_reg)
                begin
                    fr_raddr = AW'(l2 + k_reg - CW'(24));
                end
                else
                begin
                    fr_raddr = AW'(l2 + k_reg - CW'(14));
                end
                s2v_next = 1'b1;
                k_next   = k_reg + CW'(1);
                if (k_reg == blen_reg - CW'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                if (arp_reg)
                begin
                    rlen_next  = blen_reg;
                    ptr_next   = '0;
                    pend_next  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_FOLD1;
                end
            end

            ST_FOLD1:
            begin
                state_next = ST_FOLD2;
            end

            ST_FOLD2:
            begin
                state_next = ST_WR0;
            end

            ST_WR0:
            begin
                rp_we      = 1'b1;
                rp_waddr   = AW'(24);
                rp_wdata   = ipc[15:8];
                state_next = ST_WR1;
            end

            ST_WR1:
            begin
                rp_we      = 1'b1;
                rp_waddr   = AW'(25);
                rp_wdata   = ipc[7:0];
                state_next = ST_WR2;
            end

            ST_WR2:
            begin
                rp_we      = 1'b1;
                rp_waddr   = AW'(CW'(16) + CW'(ihl_reg));
                rp_wdata   = icc[15:8];
                state_next = ST_WR3;
            end

            ST_WR3:
            begin
                rp_we      = 1'b1;
                rp_waddr   = AW'(CW'(17) + CW'(ihl_reg));
                rp_wdata   = icc[7:0];
                rlen_next  = blen_reg;
                ptr_next   = '0;
                pend_next  = 1'b1;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            rlen_reg    <= '0;
            ptr_reg     <= '0;
            lastb_reg   <= 1'b0;
            learned_reg <= '0;
            verdict_reg <= VERDICT_IGNORE;
            arp_reg     <= 1'b0;
            k_reg       <= '0;
            blen_reg    <= '0;
            s2v_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            pend_reg    <= pend_next;
            rlen_reg    <= rlen_next;
            ptr_reg     <= ptr_next;
            lastb_reg   <= lastb_next;
            learned_reg <= learned_next;
            verdict_reg <= verdict_next;
            arp_reg     <= arp_next;
            k_reg       <= k_next;
            blen_reg    <= blen_next;
            s2v_reg     <= s2v_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_reg[count_reg[HW-1:0]] <= req.data_byte;
        end
        ihl_reg  <= ihl_next;
        tot_reg  <= tot_next;
        type_reg <= type_next;
        k2_reg   <= k_reg;
        if (state_reg == ST_IC_C)
        begin
            ipsum_reg <= '0;
            icsum_reg <= '0;
        end
        else if (state_reg == ST_FOLD1 || state_reg == ST_FOLD2)
        begin
            ipsum_reg <= SUM_W'(ipsum_reg[15:0]) + SUM_W'(ipsum_reg[SUM_W-1:16]);
            icsum_reg <= SUM_W'(icsum_reg[15:0]) + SUM_W'(icsum_reg[SUM_W-1:16]);
        end
        else if (s2v_reg)
        begin
            if (add_ip)
            begin
                ipsum_reg <= ipsum_reg + SUM_W'(s2_word);
            end
            if (add_ic)
            begin
                icsum_reg <= icsum_reg + SUM_W'(s2_word);
            end
        end
    end
endmodule

FILE: hw/rtl/arp_icmp_echo_responder.sv
// ----------------------------------------------------------------------------
// arp_icmp_echo_responder
// Stores pushed frames, answers ARP requests and ICMP echo requests, learns
// the sender MAC of ARP replies, and hands reply frames out byte by byte.
//
//   channel  dir  carries
//   req      in   command, data_byte, last_byte
//   rsp      out  kind, verdict, reply_data, reply_last, learned_mac
//   cfg      in   cfg_we, cfg_index, cfg_data (0 own_mac, 1 own_ip)
//
// A pushed byte is stored in the frame RAM; a pull first reads the reply RAM.
// After the final byte the frame is classified and the verdict emitted; ICMP
// frames also read type and code. A reply adds one frame RAM read per reply
// byte plus a drain state; an echo reply also adds the checksum fold and the
// patch writes.
// Results wait in an output register; req stalls while one item is in work.
// Reset clears control state only; the frame and reply RAMs are not cleared.
// ----------------------------------------------------------------------------
module arp_icmp_echo_responder #(
    parameter int MAX_FRAME = aie_pkg::MAX_FRAME_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    aie_req_if.sink     req,
    aie_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import aie_pkg::*;

    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    logic        out_valid_reg;
    res_t        out_reg;
    logic        res_valid, res_ready;
    res_t        res;

    aie_engine #(.MAX_FRAME(MAX_FRAME)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .own_mac   (own_mac_reg),
        .own_ip    (own_ip_reg),
        .req       (req),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg   <= '0;
            own_ip_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_OWN_MAC)
            begin
                own_mac_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_OWN_IP)
            begin
                own_ip_reg <= cfg_data[31:0];
            end
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = out_reg.kind;
    assign rsp.verdict     = out_reg.verdict;
    assign rsp.reply_data  = out_reg.data;
    assign rsp.reply_last  = out_reg.last;
    assign rsp.learned_mac = out_reg.learned;
endmodule
